// ===== src/ard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_pkg
// Shared types and constants of the archive deframer.
// ----------------------------------------------------------------------------
package ard_pkg;

	localparam int unsigned OFFSET_BITS = 32;
	localparam int unsigned DOFF_W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
	localparam logic [DOFF_W-1:0] OFF_MAX =
		{{(DOFF_W - OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
	localparam logic [DOFF_W-1:0] OUT_OFF_MAX =
		{{(DOFF_W - 32){1'b0}}, {32{1'b1}}};

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
	localparam logic [1:0] ST_BAD_TRAILER = 2'd2;
	localparam logic [1:0] ST_TRUNCATED   = 2'd3;

	localparam logic EVT_MEMBER = 1'b0;
	localparam logic EVT_END    = 1'b1;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_GRAVE = 8'h60;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] MAGIC_SEQ [8] =
		'{8'h21, 8'h3C, 8'h61, 8'h72, 8'h63, 8'h68, 8'h3E, 8'h0A};
	localparam logic [7:0] EXT_PREFIX [3] = '{8'h23, 8'h31, 8'h2F};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic        event_kind;
		logic [1:0]  status;
		logic [31:0] data_offset;
		logic [33:0] data_size;
		logic [39:0] mod_time;
		logic [15:0] name_length;
		logic        name_extended;
	} result_t;

endpackage

// ===== src/ard_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_parser
// Parse state and per-byte update: magic, headers, data skip and padding.
// ----------------------------------------------------------------------------
module ard_parser import ard_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output logic     res_valid,
	output result_t  res
);

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_HEADER,
		PH_SKIP,
		PH_PAD,
		PH_ERROR
	} phase_t;

	localparam logic [5:0] FI_EXT_END  = 6'd3;
	localparam logic [5:0] FI_NAME_END = 6'd16;
	localparam logic [5:0] FI_DATE     = 6'd16;
	localparam logic [5:0] FI_DATE_END = 6'd28;
	localparam logic [5:0] FI_SIZE     = 6'd48;
	localparam logic [5:0] FI_SIZE_END = 6'd58;
	localparam logic [5:0] FI_TRAIL0   = 6'd58;
	localparam logic [5:0] FI_TRAIL1   = 6'd59;
	localparam logic [5:0] HDR_LEN     = 6'd60;

	phase_t                 phase_q, phase_n;
	logic [5:0]             fidx_q, fidx_n;
	logic [OFFSET_BITS-1:0] boff_q, boff_n;
	logic [39:0]            date_q, date_n;
	logic [33:0]            size_q, size_n;
	logic [15:0]            nlen_q, nlen_n;
	logic                   dstop_q, dstop_n;
	logic                   pmatch_q, pmatch_n;
	logic [33:0]            brem_q, brem_n;

	always_comb begin
		logic [7:0]        b;
		logic              last;
		logic              st_set;
		logic [1:0]        st;
		logic              emitted;
		logic              restart;
		logic [5:0]        fi;
		logic              is_dig;
		logic [19:0]       nl_wide;
		logic [33:0]       skip;
		logic [33:0]       dsize;
		logic [33:0]       br_dec;
		logic [DOFF_W-1:0] dsum;
		logic [DOFF_W-1:0] dsat;

		b       = item.data_byte;
		last    = item.is_last;
		st_set  = 1'b0;
		st      = ST_OK;
		emitted = 1'b0;
		restart = 1'b0;
		fi      = '0;
		skip    = '0;
		dsize   = '0;
		br_dec  = '0;
		dsum    = '0;
		dsat    = '0;
		nl_wide = '0;
		is_dig  = (b >= CH_ZERO) && (b <= CH_NINE);

		phase_n  = phase_q;
		fidx_n   = fidx_q;
		date_n   = date_q;
		size_n   = size_q;
		nlen_n   = nlen_q;
		dstop_n  = dstop_q;
		pmatch_n = pmatch_q;
		brem_n   = brem_q;
		boff_n   = (boff_q != '1) ? boff_q + 1'b1 : boff_q;

		res_valid         = 1'b0;
		res.event_kind    = EVT_END;
		res.status        = ST_OK;
		res.data_offset   = '0;
		res.data_size     = '0;
		res.mod_time      = '0;
		res.name_length   = '0;
		res.name_extended = 1'b0;

		unique case (phase_q)
			PH_ERROR: begin
				if (last)
					restart = 1'b1;
			end
			PH_MAGIC: begin
				if (b != MAGIC_SEQ[fidx_q[2:0]]) begin
					st_set = 1'b1;
					st     = ST_BAD_MAGIC;
				end else if (fidx_q[2:0] == 3'd7) begin
					phase_n = PH_HEADER;
					fidx_n  = '0;
				end else begin
					fidx_n = {3'b000, fidx_q[2:0] + 3'd1};
				end
				if (last && !st_set) begin
					st_set = 1'b1;
					st     = (phase_n == PH_HEADER) ? ST_OK : ST_TRUNCATED;
				end
			end
			PH_SKIP: begin
				br_dec = (brem_q != '0) ? brem_q - 34'd1 : brem_q;
				brem_n = br_dec;
				if (br_dec == '0)
					phase_n = PH_PAD;
				if (last) begin
					st_set = 1'b1;
					st     = ST_OK;
				end
			end
			PH_HEADER, PH_PAD: begin
				if (phase_q == PH_PAD && b == CH_NL) begin
					if (last) begin
						st_set = 1'b1;
						st     = ST_OK;
					end
				end else begin
					phase_n = PH_HEADER;
					fi = (phase_q == PH_PAD) ? 6'd0 : fidx_q;
					if (fi >= HDR_LEN)
						fi = '0;
					if (fi == '0) begin
						date_n   = '0;
						size_n   = '0;
						nlen_n   = '0;
						dstop_n  = 1'b0;
						pmatch_n = 1'b1;
					end
					if (fi < FI_EXT_END) begin
						if (b != EXT_PREFIX[fi[1:0]])
							pmatch_n = 1'b0;
						if (b != CH_SPACE)
							nlen_n = 16'(fi) + 16'd1;
					end else if (fi < FI_NAME_END) begin
						if (pmatch_n) begin
							if (fi == FI_EXT_END) begin
								nlen_n  = '0;
								dstop_n = 1'b0;
							end
							if (!dstop_n) begin
								if (is_dig) begin
									nl_wide = ({4'b0000, nlen_n} << 3) + ({4'b0000, nlen_n} << 1)
										+ 20'(b[3:0]);
									nlen_n = (nl_wide > 20'hFFFF) ? 16'hFFFF : nl_wide[15:0];
								end else begin
									dstop_n = 1'b1;
								end
							end
						end else if (b != CH_SPACE) begin
							nlen_n = 16'(fi) + 16'd1;
						end
					end else if (fi < FI_DATE_END) begin
						if (fi == FI_DATE)
							dstop_n = 1'b0;
						if (!dstop_n) begin
							if (is_dig)
								date_n = (date_n << 3) + (date_n << 1) + 40'(b[3:0]);
							else
								dstop_n = 1'b1;
						end
					end else if (fi >= FI_SIZE && fi < FI_SIZE_END) begin
						if (fi == FI_SIZE)
							dstop_n = 1'b0;
						if (!dstop_n) begin
							if (is_dig)
								size_n = (size_n << 3) + (size_n << 1) + 34'(b[3:0]);
							else
								dstop_n = 1'b1;
						end
					end else if (fi == FI_TRAIL0) begin
						if (b != CH_GRAVE) begin
							st_set = 1'b1;
							st     = ST_BAD_TRAILER;
						end
					end else if (fi == FI_TRAIL1) begin
						if (b != CH_NL) begin
							st_set = 1'b1;
							st     = ST_BAD_TRAILER;
						end else begin
							skip  = pmatch_n ? 34'(nlen_n) : 34'd0;
							dsize = size_n;
							if (pmatch_n)
								dsize = (size_n > 34'(nlen_n)) ? size_n - 34'(nlen_n) : 34'd0;
							dsum = DOFF_W'(boff_q) + DOFF_W'(skip) + DOFF_W'(1);
							dsat = (dsum > OFF_MAX) ? OFF_MAX : dsum;
							emitted           = 1'b1;
							res_valid         = 1'b1;
							res.event_kind    = EVT_MEMBER;
							res.status        = ST_OK;
							res.data_offset   = (dsat > OUT_OFF_MAX) ? 32'hFFFF_FFFF : dsat[31:0];
							res.data_size     = dsize;
							res.mod_time      = date_n;
							res.name_length   = nlen_n;
							res.name_extended = pmatch_n;
							brem_n  = skip + dsize;
							phase_n = (brem_n != '0) ? PH_SKIP : PH_PAD;
						end
					end
					fidx_n = (fi == FI_TRAIL1) ? 6'd0 : fi + 6'd1;
					if (last && !st_set && !emitted) begin
						st_set = 1'b1;
						st     = ST_TRUNCATED;
					end
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		if (emitted) begin
			if (last)
				restart = 1'b1;
		end else if (st_set) begin
			res_valid      = 1'b1;
			res.event_kind = EVT_END;
			res.status     = st;
			if (st == ST_BAD_MAGIC || st == ST_BAD_TRAILER) begin
				if (last)
					restart = 1'b1;
				else
					phase_n = PH_ERROR;
			end else begin
				restart = 1'b1;
			end
		end

		if (restart) begin
			phase_n  = PH_MAGIC;
			fidx_n   = '0;
			boff_n   = '0;
			date_n   = '0;
			size_n   = '0;
			nlen_n   = '0;
			dstop_n  = 1'b0;
			pmatch_n = 1'b1;
			brem_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			fidx_q   <= '0;
			boff_q   <= '0;
			date_q   <= '0;
			size_q   <= '0;
			nlen_q   <= '0;
			dstop_q  <= 1'b0;
			pmatch_q <= 1'b1;
			brem_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			fidx_q   <= fidx_n;
			boff_q   <= boff_n;
			date_q   <= date_n;
			size_q   <= size_n;
			nlen_q   <= nlen_n;
			dstop_q  <= dstop_n;
			pmatch_q <= pmatch_n;
			brem_q   <= brem_n;
		end
	end

endmodule

// ===== src/ard_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_out_reg
// Result register in front of the master-side stream port.
// ----------------------------------------------------------------------------
module ard_out_reg import ard_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    res_valid,
	input  result_t res,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (out_ready)
				valid_q <= 1'b0;
			if (load && res_valid)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid)
			res_q <= res;
	end

endmodule

// ===== src/ar_archive_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ar_archive_deframer
// Byte-stream parser for ar archives: one event per member, at most one end report.
// ----------------------------------------------------------------------------
// The slave side takes one archive byte per transaction in s_axis_tdata;
// s_axis_tlast marks the final byte of the archive. The master side gives
// one transaction per member header found (m_axis_tuser low) and one end
// report (m_axis_tuser high) with a status on the last byte or on the first
// error. A header completed by the last byte gives only the member event.
// After an error the bytes up to the last one are dropped without output.
// Each byte is held in an input register, parsed from there, and its result
// is registered in the result register in front of the master port. One
// byte is taken every cycle while the result register can be freed; the
// state update with its decimal multiply-by-ten accumulate sets that rate.
// When the receiver stalls, the result register holds and the input
// register fills; s_axis_tready falls only when both are occupied.
// Reset clears the parse state to the start of a new archive and empties
// both registers.
// ----------------------------------------------------------------------------
module ar_archive_deframer import ard_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tlast,  // is_last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // status, data_offset, data_size, mod_time,
	                                    // name_length, name_extended, zero fill
	output logic         m_axis_tuser   // event_kind
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     free;
	logic     advance;
	logic     res_valid;
	result_t  res;
	result_t  out_res;

	assign advance       = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte <= s_axis_tdata;
			item_s1.is_last   <= s_axis_tlast;
		end
	end

	ard_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ard_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tuser = out_res.event_kind;
	assign m_axis_tdata = {3'b000, out_res.name_extended, out_res.name_length,
		out_res.mod_time, out_res.data_size, out_res.data_offset, out_res.status};

endmodule

// ===== sim/ar_archive_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ar_archive_deframer_tb
// Self-checking bench for the ar archive byte-stream deframer.
// Archives are built byte by byte: first a table of short directed archives
// that cover the magic, header, trailer and truncation corner cases, then
// random archives that are mostly well formed. Random archives also include
// corrupted magic, broken trailers, cut streams and plain noise. Each accepted
// byte runs through a local deframer that yields the expected events. Every
// output transaction is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ar_archive_deframer_tb;
	import ard_pkg::*;

	localparam int PREDICTED = -1;
	localparam int NO_FAULT  = -1;
	localparam int NO_CUT    = -1;

	localparam int TRL_GOOD      = 0;
	localparam int TRL_BAD_GRAVE = 1;
	localparam int TRL_BAD_NL    = 2;

	typedef enum logic [2:0] {AP_MAGIC, AP_HEADER, AP_SKIP, AP_PAD, AP_ERROR} arc_phase_t;

	typedef struct {
		string name;
		string date;
		string size;
		int    trailer;
		int    bad_magic;
		int    body;
		int    pads;
		int    keep;
		int    end_status;
	} dir_case_t;

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata  = 8'h00;
	logic         s_axis_tlast  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser;

	arc_phase_t      ph;
	int unsigned     hdr_idx;
	longint unsigned arc_pos;
	longint unsigned date_acc;
	longint unsigned size_acc;
	int unsigned     name_len_acc;
	logic            digits_done;
	logic            ext_form;
	longint unsigned skip_left;

	result_t     pending_events[$];
	logic [7:0]  arc[$];
	int unsigned send_idle_pct = 31;
	int unsigned recv_idle_pct = 45;
	int unsigned errors        = 0;
	int unsigned bytes_fed     = 0;
	int unsigned results_due   = 0;
	int unsigned members_due   = 0;
	int unsigned ends_due      = 0;
	int unsigned archives      = 0;

	dir_case_t dir_cases [18] = '{
		'{"hello.o/", "1700000000", "4", TRL_GOOD, NO_FAULT, 4, 1, NO_CUT, ST_OK},
		'{"x", "0", "0", TRL_GOOD, 0, 0, 0, 5, ST_BAD_MAGIC},
		'{"x", "0", "0", TRL_GOOD, 7, 0, 0, 8, ST_BAD_MAGIC},
		'{"x", "0", "0", TRL_GOOD, NO_FAULT, 0, 0, 8, ST_OK},
		'{"x", "0", "0", TRL_GOOD, NO_FAULT, 0, 0, 3, ST_TRUNCATED},
		'{"trunc", "1", "1", TRL_GOOD, NO_FAULT, 1, 0, 38, ST_TRUNCATED},
		'{"exact", "2", "0", TRL_GOOD, NO_FAULT, 0, 0, 68, PREDICTED},
		'{"badgrave", "3", "2", TRL_BAD_GRAVE, NO_FAULT, 3, 0, NO_CUT, ST_BAD_TRAILER},
		'{"badnl", "4", "0", TRL_BAD_NL, NO_FAULT, 0, 0, NO_CUT, ST_BAD_TRAILER},
		'{"#1/20", "999999999999", "30", TRL_GOOD, NO_FAULT, 30, 2, NO_CUT, ST_OK},
		'{"abcdefghijklmnop", "0", "9999999999", TRL_GOOD, NO_FAULT, 5, 0, NO_CUT, ST_OK},
		'{"#1/9999999999999", "5", "70000", TRL_GOOD, NO_FAULT, 3, 0, NO_CUT, ST_OK},
		'{"#1/40", "6", "12", TRL_GOOD, NO_FAULT, 2, 0, NO_CUT, ST_OK},
		'{"ab", "-12", "12a4", TRL_GOOD, NO_FAULT, 12, 0, NO_CUT, ST_OK},
		'{"#1x/5 z", "  5", "7", TRL_GOOD, NO_FAULT, 7, 3, NO_CUT, ST_OK},
		'{"", "", "", TRL_GOOD, NO_FAULT, 0, 2, NO_CUT, ST_OK},
		'{"#1/", "7", "5", TRL_GOOD, NO_FAULT, 5, 1, NO_CUT, ST_OK},
		'{"#1/65535", "8", "65535", TRL_GOOD, NO_FAULT, 2, 0, NO_CUT, ST_OK}
	};

	ar_archive_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void restart_archive();
		ph           = AP_MAGIC;
		hdr_idx      = 0;
		arc_pos      = 0;
		date_acc     = 0;
		size_acc     = 0;
		name_len_acc = 0;
		digits_done  = 1'b0;
		ext_form     = 1'b1;
		skip_left    = 0;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic last,
			output logic got, output result_t r);
		longint unsigned idx, nl, skip_name, dsize, doff;
		int unsigned fi, v;
		int status;
		logic emitted;
		got     = 1'b0;
		r       = '0;
		status  = -1;
		emitted = 1'b0;
		idx     = arc_pos;
		if (arc_pos < OFF_MAX)
			arc_pos++;
		if (ph == AP_ERROR) begin
			if (last)
				restart_archive();
			return;
		end
		if (ph == AP_MAGIC) begin
			fi = hdr_idx & 7;
			if (b != MAGIC_SEQ[fi]) begin
				status = ST_BAD_MAGIC;
			end else if (fi == 7) begin
				ph      = AP_HEADER;
				hdr_idx = 0;
			end else begin
				hdr_idx = fi + 1;
			end
			if (last && status < 0)
				status = (ph == AP_HEADER) ? ST_OK : ST_TRUNCATED;
		end else if (ph == AP_SKIP) begin
			if (skip_left > 0)
				skip_left--;
			if (skip_left == 0)
				ph = AP_PAD;
			if (last)
				status = ST_OK;
		end else if (ph == AP_PAD && b == CH_NL) begin
			if (last)
				status = ST_OK;
		end else begin
			if (ph == AP_PAD) begin
				ph      = AP_HEADER;
				hdr_idx = 0;
			end
			fi = (hdr_idx >= 60) ? 0 : hdr_idx;
			if (fi == 0) begin
				date_acc     = 0;
				size_acc     = 0;
				name_len_acc = 0;
				digits_done  = 1'b0;
				ext_form     = 1'b1;
			end
			if (fi < 3) begin
				if (b != EXT_PREFIX[fi])
					ext_form = 1'b0;
				if (b != CH_SPACE)
					name_len_acc = fi + 1;
			end else if (fi < 16) begin
				if (ext_form) begin
					if (fi == 3) begin
						name_len_acc = 0;
						digits_done  = 1'b0;
					end
					if (!digits_done) begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							v = name_len_acc * 10 + (b - CH_ZERO);
							name_len_acc = (v > 65535) ? 65535 : v;
						end else begin
							digits_done = 1'b1;
						end
					end
				end else if (b != CH_SPACE) begin
					name_len_acc = fi + 1;
				end
			end else if (fi < 28) begin
				if (fi == 16)
					digits_done = 1'b0;
				if (!digits_done) begin
					if (b >= CH_ZERO && b <= CH_NINE)
						date_acc = date_acc * 10 + (b - CH_ZERO);
					else
						digits_done = 1'b1;
				end
			end else if (fi >= 48 && fi < 58) begin
				if (fi == 48)
					digits_done = 1'b0;
				if (!digits_done) begin
					if (b >= CH_ZERO && b <= CH_NINE)
						size_acc = size_acc * 10 + (b - CH_ZERO);
					else
						digits_done = 1'b1;
				end
			end else if (fi == 58) begin
				if (b != CH_GRAVE)
					status = ST_BAD_TRAILER;
			end else if (fi == 59) begin
				if (b != CH_NL) begin
					status = ST_BAD_TRAILER;
				end else begin
					nl        = name_len_acc;
					skip_name = ext_form ? nl : 0;
					dsize     = size_acc;
					if (1 + skip_name >= OFF_MAX || idx > OFF_MAX - (1 + skip_name))
						doff = OFF_MAX;
					else
						doff = idx + 1 + skip_name;
					if (ext_form)
						dsize = (dsize > nl) ? dsize - nl : 0;
					r.event_kind    = EVT_MEMBER;
					r.status        = ST_OK;
					r.data_offset   = (doff > OUT_OFF_MAX) ? 32'hFFFF_FFFF : doff[31:0];
					r.data_size     = dsize[33:0];
					r.mod_time      = date_acc[39:0];
					r.name_length   = nl[15:0];
					r.name_extended = ext_form;
					emitted         = 1'b1;
					skip_left       = skip_name + dsize;
					ph              = (skip_left != 0) ? AP_SKIP : AP_PAD;
				end
			end
			hdr_idx = (fi == 59) ? 0 : fi + 1;
			if (last && status < 0 && !emitted)
				status = ST_TRUNCATED;
		end
		if (emitted) begin
			got = 1'b1;
			if (last)
				restart_archive();
			return;
		end
		if (status < 0)
			return;
		got          = 1'b1;
		r            = '0;
		r.event_kind = EVT_END;
		r.status     = status[1:0];
		if (status == ST_BAD_MAGIC || status == ST_BAD_TRAILER) begin
			if (last)
				restart_archive();
			else
				ph = AP_ERROR;
		end else begin
			restart_archive();
		end
	endtask

	task automatic feed(input logic [7:0] b, input logic last, input int typed_end);
		logic got;
		result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_fed++;
		deframe_byte(b, last, got, r);
		if (got) begin
			if (typed_end >= 0 && r.event_kind == EVT_END) begin
				r            = '0;
				r.event_kind = EVT_END;
				r.status     = typed_end[1:0];
			end
			pending_events.push_back(r);
			results_due++;
			if (r.event_kind == EVT_END)
				ends_due++;
			else
				members_due++;
		end
	endtask

	task automatic feed_archive(input int typed_end);
		foreach (arc[i])
			feed(arc[i], i == arc.size() - 1, typed_end);
	endtask

	function automatic void put_text(string s, int width);
		for (int i = 0; i < width; i++)
			arc.push_back((i < s.len()) ? 8'(s[i]) : CH_SPACE);
	endfunction

	function automatic void put_magic();
		foreach (MAGIC_SEQ[i])
			arc.push_back(MAGIC_SEQ[i]);
	endfunction

	function automatic void put_header(string name, string date, string size,
			int trailer, logic noisy);
		put_text(name, 16);
		put_text(date, 12);
		if (noisy) begin
			for (int i = 0; i < 20; i++)
				arc.push_back(8'($urandom_range(0, 255)));
		end else begin
			put_text("0", 6);
			put_text("0", 6);
			put_text("100644", 8);
		end
		put_text(size, 10);
		arc.push_back((trailer == TRL_BAD_GRAVE) ? CH_SPACE : CH_GRAVE);
		arc.push_back((trailer == TRL_BAD_NL) ? 8'h0D : CH_NL);
	endfunction

	function automatic string digit_text(int unsigned width);
		string s;
		int unsigned n;
		s = "";
		n = $urandom_range(0, width);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 11) == 0)
				s = $sformatf("%s%c", s, ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'h2D);
			else
				s = $sformatf("%s%0d", s, $urandom_range(0, 9));
		end
		return s;
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
		end
	endfunction

	always @(posedge clk) begin : sink
		result_t want, seen;
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.event_kind    = m_axis_tuser;
			seen.status        = m_axis_tdata[1:0];
			seen.data_offset   = m_axis_tdata[33:2];
			seen.data_size     = m_axis_tdata[67:34];
			seen.mod_time      = m_axis_tdata[107:68];
			seen.name_length   = m_axis_tdata[123:108];
			seen.name_extended = m_axis_tdata[124];
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t: extra transaction, expected none, actual tuser %b tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", want.event_kind, seen.event_kind);
				check_field("status", want.status, seen.status);
				check_field("data_offset", want.data_offset, seen.data_offset);
				check_field("data_size", want.data_size, seen.data_size);
				check_field("mod_time", want.mod_time, seen.mod_time);
				check_field("name_length", want.name_length, seen.name_length);
				check_field("name_extended", want.name_extended, seen.name_extended);
			end
		end
	end

	initial begin : stimulus
		int unsigned mode, n_members, ext_len, data_len, name_len, k;
		logic is_ext;
		string nm, sz;
		int fault;
		restart_archive();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_cases[c]) begin
			arc.delete();
			put_magic();
			if (dir_cases[c].bad_magic != NO_FAULT)
				arc[dir_cases[c].bad_magic] = ~arc[dir_cases[c].bad_magic];
			put_header(dir_cases[c].name, dir_cases[c].date, dir_cases[c].size,
				dir_cases[c].trailer, 1'b0);
			repeat (dir_cases[c].body)
				arc.push_back(8'($urandom_range(0, 255)));
			repeat (dir_cases[c].pads)
				arc.push_back(CH_NL);
			if (dir_cases[c].keep != NO_CUT && dir_cases[c].keep < arc.size())
				arc = arc[0:dir_cases[c].keep - 1];
			feed_archive(dir_cases[c].end_status);
			archives++;
		end

		while (bytes_fed < 1950 || results_due < 60) begin
			if (bytes_fed >= 1300) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (bytes_fed >= 650) begin
				send_idle_pct = 45;
				recv_idle_pct = 31;
			end
			arc.delete();
			mode = $urandom_range(0, 99);
			if (mode >= 96) begin
				repeat ($urandom_range(1, 30))
					arc.push_back(8'($urandom_range(0, 255)));
			end else begin
				put_magic();
				if (mode < 4) begin
					k = $urandom_range(0, 7);
					arc[k] = arc[k] ^ 8'($urandom_range(1, 255));
				end
				n_members = $urandom_range(1, 4);
				for (int m = 0; m < n_members; m++) begin
					is_ext   = ($urandom_range(0, 2) == 0);
					ext_len  = is_ext ? $urandom_range(0, 20) : 0;
					data_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
					if (is_ext) begin
						nm = $sformatf("#1/%0d", ext_len);
					end else begin
						nm = "";
						name_len = $urandom_range(1, 16);
						for (int i = 0; i < name_len; i++)
							nm = $sformatf("%s%c", nm, ($urandom_range(0, 9) == 0) ?
								CH_SPACE : 8'($urandom_range(8'h21, 8'h7E)));
					end
					if ($urandom_range(0, 9) == 0)
						sz = digit_text(10);
					else
						sz = $sformatf("%0d", ext_len + data_len);
					fault = TRL_GOOD;
					if (mode >= 4 && mode < 8 && m == n_members - 1)
						fault = ($urandom_range(0, 1) != 0) ? TRL_BAD_GRAVE : TRL_BAD_NL;
					put_header(nm, digit_text(12), sz, fault, 1'b1);
					repeat (ext_len + data_len)
						arc.push_back(8'($urandom_range(0, 255)));
					repeat ($urandom_range(0, 3))
						arc.push_back(CH_NL);
				end
				if (mode >= 8 && mode < 20) begin
					k = $urandom_range(1, arc.size());
					arc = arc[0:k - 1];
				end
			end
			feed_archive(PREDICTED);
			archives++;
		end
		s_axis_tvalid <= 1'b0;

		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Fed %0d bytes in %0d archives under three idle patterns.", bytes_fed, archives);
		$display("Checked %0d member events and %0d end reports.", members_due, ends_due);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ard_pkg.sv
src/ard_parser.sv
src/ard_out_reg.sv
src/ar_archive_deframer.sv
sim/ar_archive_deframer_tb.sv
